// ===== sv/jtsc_pkg.sv =====
// ----------------------------------------------------------------------------
// jtsc_pkg: shared types and codes for the JSON token structure checker
// Parser modes, token kinds, event kinds, error codes and stack commands.
// ----------------------------------------------------------------------------
package jtsc_pkg;

	// default depth of the return stack
	localparam int MAX_DEPTH_DEF = 64;

	// depth limit register
	localparam int LIMIT_W = 7;
	localparam logic [LIMIT_W-1:0] DEPTH_LIMIT_RST = 7'd64;

	// field widths
	localparam int TOKEN_W = 4;
	localparam int TAG_W   = 32;
	localparam int EVENT_W = 4;
	localparam int CODE_W  = 3;
	localparam int DOUT_W  = 7;

	// token kinds
	localparam logic [TOKEN_W-1:0] TOK_NULL    = 4'd0;
	localparam logic [TOKEN_W-1:0] TOK_BOOL    = 4'd1;
	localparam logic [TOKEN_W-1:0] TOK_STRING  = 4'd2;
	localparam logic [TOKEN_W-1:0] TOK_NUMBER  = 4'd3;
	localparam logic [TOKEN_W-1:0] TOK_ARR_OPEN  = 4'd4;
	localparam logic [TOKEN_W-1:0] TOK_ARR_CLOSE = 4'd5;
	localparam logic [TOKEN_W-1:0] TOK_OBJ_OPEN  = 4'd6;
	localparam logic [TOKEN_W-1:0] TOK_OBJ_CLOSE = 4'd7;
	localparam logic [TOKEN_W-1:0] TOK_COMMA   = 4'd8;
	localparam logic [TOKEN_W-1:0] TOK_COLON   = 4'd9;
	localparam logic [TOKEN_W-1:0] TOK_EOI     = 4'd10;
	localparam logic [TOKEN_W-1:0] TOK_LEX     = 4'd11;

	// parser modes
	typedef enum logic [3:0] {
		M_INIT      = 4'd0,
		M_ARR_START = 4'd1,
		M_ARR_VALUE = 4'd2,
		M_ARR_DELIM = 4'd3,
		M_OBJ_START = 4'd4,
		M_OBJ_KEY   = 4'd5,
		M_OBJ_COLON = 4'd6,
		M_OBJ_VALUE = 4'd7,
		M_OBJ_DELIM = 4'd8,
		M_END       = 4'd9,
		M_ERROR     = 4'd10
	} mode_t;

	// structural events
	typedef enum logic [EVENT_W-1:0] {
		EV_SCALAR    = 4'd0,
		EV_BEGIN_ARR = 4'd1,
		EV_END_ARR   = 4'd2,
		EV_BEGIN_OBJ = 4'd3,
		EV_END_OBJ   = 4'd4,
		EV_KEY       = 4'd5,
		EV_SEP       = 4'd6,
		EV_DONE      = 4'd7,
		EV_ERROR     = 4'd8
	} event_t;

	// error codes
	typedef enum logic [CODE_W-1:0] {
		E_NONE       = 3'd0,
		E_UNEXPECTED = 3'd1,
		E_UNTERM_ARR = 3'd2,
		E_UNTERM_OBJ = 3'd3,
		E_EMPTY      = 3'd4,
		E_DEEP       = 3'd5,
		E_LEX        = 3'd6
	} err_t;

	// return stack command from the controller
	typedef struct packed {
		logic push;      // write a return bit for the container being opened
		logic pop;       // close a nested container, take the next top
		logic push_obj;  // return mode is object value
	} stack_cmd_t;

endpackage

// ===== sv/jtsc_stack.sv =====
// ----------------------------------------------------------------------------
// jtsc_stack: return-mode stack
// One-bit synchronous memory with a registered top entry and a prefetch
// of the entry below it, so push and pop both update the registered top directly.
// ----------------------------------------------------------------------------
module jtsc_stack #(
	parameter int MAX_DEPTH = jtsc_pkg::MAX_DEPTH_DEF,
	parameter int DW = $clog2(MAX_DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  jtsc_pkg::stack_cmd_t  cmd,
	input  logic [DW-1:0]         cur_depth,
	input  logic [DW-1:0]         nxt_depth,
	output logic                  tos
);

	localparam int AW = $clog2(MAX_DEPTH);

	logic          mem [MAX_DEPTH];
	logic          below_q;
	logic          tos_q;
	logic [AW-1:0] wr_idx;
	logic [AW-1:0] rd_idx;
	logic [DW-1:0] rd_full;

	// entry d holds the return mode of the container opened from depth d
	assign wr_idx  = cur_depth[AW-1:0];
	// prefetch the entry under the new top (wraps harmlessly below depth 2)
	assign rd_full = nxt_depth - DW'(2);
	assign rd_idx  = rd_full[AW-1:0];

	// memory write port
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_idx] <= cmd.push_obj;
		end
	end

	// memory read port, registered; never the address written this edge
	always_ff @(posedge clk) begin
		below_q <= mem[rd_idx];
	end

	// top of stack cache
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tos_q <= 1'b0;
		end else if (cmd.push) begin
			tos_q <= cmd.push_obj;
		end else if (cmd.pop) begin
			tos_q <= below_q;
		end
	end

	assign tos = tos_q;

endmodule

// ===== sv/jtsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// jtsc_ctrl: parser state machine
// Holds mode and depth, decides the transition for one token word and
// forms the structural event; drives the return stack.
// ----------------------------------------------------------------------------
module jtsc_ctrl #(
	parameter int MAX_DEPTH = jtsc_pkg::MAX_DEPTH_DEF,
	parameter int DW = $clog2(MAX_DEPTH + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step,
	input  logic [jtsc_pkg::TOKEN_W-1:0]       token_kind,
	input  logic [jtsc_pkg::LIMIT_W-1:0]       depth_limit,
	input  logic                               tos,
	output jtsc_pkg::stack_cmd_t               cmd,
	output logic [DW-1:0]                      cur_depth,
	output logic [DW-1:0]                      nxt_depth,
	output jtsc_pkg::event_t                   ev_kind,
	output jtsc_pkg::err_t                     ev_code,
	output logic [jtsc_pkg::DOUT_W-1:0]        ev_depth,
	output logic                               ev_obj
);

	// compare width wide enough for depth + 1 and the limit register
	localparam int CW = ((DW > jtsc_pkg::LIMIT_W) ? DW : jtsc_pkg::LIMIT_W) + 1;

	jtsc_pkg::mode_t mode_q;
	jtsc_pkg::mode_t nxt_mode;
	logic [DW-1:0]   depth_q;
	logic [DW-1:0]   depth_d;
	jtsc_pkg::err_t  err_d;
	logic            push_d;
	logic            pop_d;
	logic            push_obj_d;
	logic [CW-1:0]   lim;
	logic [CW-1:0]   nd_wide;
	logic [CW-1:0]   limit_wide;

	assign limit_wide = CW'(depth_limit);
	assign lim        = (limit_wide < CW'(MAX_DEPTH)) ? limit_wide : CW'(MAX_DEPTH);
	assign nd_wide    = CW'(depth_q) + CW'(1);

	// next state
	always_comb begin
		logic is_scalar;
		logic in_arr;
		logic in_obj;
		logic go_err;
		logic open_req;
		logic open_ret;
		logic close_req;
		is_scalar  = (token_kind <= jtsc_pkg::TOK_NUMBER);
		in_arr     = (mode_q >= jtsc_pkg::M_ARR_START) && (mode_q <= jtsc_pkg::M_ARR_DELIM);
		in_obj     = (mode_q >= jtsc_pkg::M_OBJ_START) && (mode_q <= jtsc_pkg::M_OBJ_DELIM);
		go_err     = 1'b0;
		open_req   = 1'b0;
		open_ret   = 1'b0;
		close_req  = 1'b0;
		nxt_mode   = mode_q;
		depth_d    = depth_q;
		err_d      = jtsc_pkg::E_NONE;
		push_d     = 1'b0;
		pop_d      = 1'b0;
		push_obj_d = 1'b0;

		priority if (mode_q == jtsc_pkg::M_ERROR) begin
			go_err = 1'b1;
			err_d  = jtsc_pkg::E_UNEXPECTED;
		end else if (token_kind == jtsc_pkg::TOK_LEX) begin
			go_err = 1'b1;
			err_d  = jtsc_pkg::E_LEX;
		end else if (token_kind == jtsc_pkg::TOK_EOI) begin
			// end of input: done only after a complete value
			priority if (mode_q == jtsc_pkg::M_END) begin
				go_err = 1'b0;
			end else if (mode_q == jtsc_pkg::M_INIT) begin
				go_err = 1'b1;
				err_d  = jtsc_pkg::E_EMPTY;
			end else if (in_arr) begin
				go_err = 1'b1;
				err_d  = jtsc_pkg::E_UNTERM_ARR;
			end else if (in_obj) begin
				go_err = 1'b1;
				err_d  = jtsc_pkg::E_UNTERM_OBJ;
			end else begin
				go_err = 1'b1;
				err_d  = jtsc_pkg::E_UNEXPECTED;
			end
		end else begin
			// by default a token is unexpected
			go_err = 1'b1;
			err_d  = jtsc_pkg::E_UNEXPECTED;
			unique case (mode_q)
				jtsc_pkg::M_INIT: begin
					if (is_scalar) begin
						go_err   = 1'b0;
						nxt_mode = jtsc_pkg::M_END;
					end else if (token_kind == jtsc_pkg::TOK_ARR_OPEN ||
							token_kind == jtsc_pkg::TOK_OBJ_OPEN) begin
						go_err   = 1'b0;
						open_req = 1'b1;
					end
				end
				jtsc_pkg::M_ARR_START, jtsc_pkg::M_ARR_DELIM: begin
					if (is_scalar) begin
						go_err   = 1'b0;
						nxt_mode = jtsc_pkg::M_ARR_VALUE;
					end else if (token_kind == jtsc_pkg::TOK_ARR_OPEN ||
							token_kind == jtsc_pkg::TOK_OBJ_OPEN) begin
						go_err   = 1'b0;
						open_req = 1'b1;
					end else if (token_kind == jtsc_pkg::TOK_ARR_CLOSE &&
							mode_q == jtsc_pkg::M_ARR_START) begin
						go_err    = 1'b0;
						close_req = 1'b1;
					end
				end
				jtsc_pkg::M_ARR_VALUE: begin
					if (token_kind == jtsc_pkg::TOK_COMMA) begin
						go_err   = 1'b0;
						nxt_mode = jtsc_pkg::M_ARR_DELIM;
					end else if (token_kind == jtsc_pkg::TOK_ARR_CLOSE) begin
						go_err    = 1'b0;
						close_req = 1'b1;
					end
				end
				jtsc_pkg::M_OBJ_START, jtsc_pkg::M_OBJ_DELIM: begin
					if (token_kind == jtsc_pkg::TOK_STRING) begin
						go_err   = 1'b0;
						nxt_mode = jtsc_pkg::M_OBJ_KEY;
					end else if (token_kind == jtsc_pkg::TOK_OBJ_CLOSE &&
							mode_q == jtsc_pkg::M_OBJ_START) begin
						go_err    = 1'b0;
						close_req = 1'b1;
					end
				end
				jtsc_pkg::M_OBJ_KEY: begin
					if (token_kind == jtsc_pkg::TOK_COLON) begin
						go_err   = 1'b0;
						nxt_mode = jtsc_pkg::M_OBJ_COLON;
					end
				end
				jtsc_pkg::M_OBJ_COLON: begin
					if (is_scalar) begin
						go_err   = 1'b0;
						nxt_mode = jtsc_pkg::M_OBJ_VALUE;
					end else if (token_kind == jtsc_pkg::TOK_ARR_OPEN ||
							token_kind == jtsc_pkg::TOK_OBJ_OPEN) begin
						go_err   = 1'b0;
						open_req = 1'b1;
						open_ret = 1'b1;
					end
				end
				jtsc_pkg::M_OBJ_VALUE: begin
					if (token_kind == jtsc_pkg::TOK_COMMA) begin
						go_err   = 1'b0;
						nxt_mode = jtsc_pkg::M_OBJ_DELIM;
					end else if (token_kind == jtsc_pkg::TOK_OBJ_CLOSE) begin
						go_err    = 1'b0;
						close_req = 1'b1;
					end
				end
				default: begin
					go_err = 1'b1;
				end
			endcase
		end

		// open a container, checking the depth limit
		if (open_req) begin
			if (nd_wide > lim) begin
				go_err = 1'b1;
				err_d  = jtsc_pkg::E_DEEP;
			end else begin
				push_d     = (depth_q != '0);
				push_obj_d = open_ret;
				depth_d    = nd_wide[DW-1:0];
				nxt_mode   = (token_kind == jtsc_pkg::TOK_OBJ_OPEN) ?
					jtsc_pkg::M_OBJ_START : jtsc_pkg::M_ARR_START;
			end
		end

		// close a container: outermost ends the value, else return via stack
		if (close_req) begin
			if (depth_q <= DW'(1)) begin
				depth_d  = '0;
				nxt_mode = jtsc_pkg::M_END;
			end else begin
				depth_d  = depth_q - DW'(1);
				pop_d    = 1'b1;
				nxt_mode = tos ? jtsc_pkg::M_OBJ_VALUE : jtsc_pkg::M_ARR_VALUE;
			end
		end

		// errors are sticky and drop all nesting
		if (go_err) begin
			nxt_mode = jtsc_pkg::M_ERROR;
			depth_d  = '0;
		end
	end

	// event outputs
	always_comb begin
		logic is_err;
		is_err  = (nxt_mode == jtsc_pkg::M_ERROR);
		ev_code = is_err ? err_d : jtsc_pkg::E_NONE;
		if (is_err) begin
			ev_kind = jtsc_pkg::EV_ERROR;
		end else begin
			unique case (token_kind)
				jtsc_pkg::TOK_NULL, jtsc_pkg::TOK_BOOL, jtsc_pkg::TOK_NUMBER:
					ev_kind = jtsc_pkg::EV_SCALAR;
				jtsc_pkg::TOK_STRING:
					ev_kind = (nxt_mode == jtsc_pkg::M_OBJ_KEY) ?
						jtsc_pkg::EV_KEY : jtsc_pkg::EV_SCALAR;
				jtsc_pkg::TOK_ARR_OPEN:  ev_kind = jtsc_pkg::EV_BEGIN_ARR;
				jtsc_pkg::TOK_ARR_CLOSE: ev_kind = jtsc_pkg::EV_END_ARR;
				jtsc_pkg::TOK_OBJ_OPEN:  ev_kind = jtsc_pkg::EV_BEGIN_OBJ;
				jtsc_pkg::TOK_OBJ_CLOSE: ev_kind = jtsc_pkg::EV_END_OBJ;
				jtsc_pkg::TOK_COMMA, jtsc_pkg::TOK_COLON:
					ev_kind = jtsc_pkg::EV_SEP;
				jtsc_pkg::TOK_EOI:       ev_kind = jtsc_pkg::EV_DONE;
				default:                 ev_kind = jtsc_pkg::EV_ERROR;
			endcase
		end
		ev_depth = is_err ? '0 : jtsc_pkg::DOUT_W'(depth_d);
		ev_obj   = !is_err && (nxt_mode >= jtsc_pkg::M_OBJ_START) &&
			(nxt_mode <= jtsc_pkg::M_OBJ_DELIM);
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= jtsc_pkg::M_INIT;
			depth_q <= '0;
		end else if (step) begin
			mode_q  <= nxt_mode;
			depth_q <= depth_d;
		end
	end

	assign cmd.push     = step && push_d;
	assign cmd.pop      = step && pop_d;
	assign cmd.push_obj = push_obj_d;
	assign cur_depth    = depth_q;
	assign nxt_depth    = step ? depth_d : depth_q;

endmodule

// ===== sv/json_token_structure_checker.sv =====
// ----------------------------------------------------------------------------
// json_token_structure_checker: JSON structure checker on a token stream
// Output: the event word is registered, valid in the cycle after token accept.
// Throughput: one token word per cycle unless out_ready stalls; stack push/pop
// and mode update at the accept edge via a cached top entry and prefetch.
// Reset: mode initial, depth zero, depth limit 64; stack contents undefined.
// ----------------------------------------------------------------------------
module json_token_structure_checker #(
	parameter int MAX_DEPTH = jtsc_pkg::MAX_DEPTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_wr_en,
	input  logic [jtsc_pkg::LIMIT_W-1:0]     cfg_wr_data,
	// token channel
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [jtsc_pkg::TOKEN_W-1:0]     token_kind,
	input  logic [jtsc_pkg::TAG_W-1:0]       token_ref,
	// event channel
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [jtsc_pkg::EVENT_W-1:0]     event_res,
	output logic [jtsc_pkg::CODE_W-1:0]      error_code,
	output logic [jtsc_pkg::DOUT_W-1:0]      nesting_depth_out,
	output logic                             in_object,
	output logic [jtsc_pkg::TAG_W-1:0]       tag_out
);

	localparam int DW = $clog2(MAX_DEPTH + 1);

	logic [jtsc_pkg::LIMIT_W-1:0] depth_limit_q;
	logic                         step;
	logic                         tos;
	jtsc_pkg::stack_cmd_t         cmd;
	logic [DW-1:0]                cur_depth;
	logic [DW-1:0]                nxt_depth;
	jtsc_pkg::event_t             ev_kind;
	jtsc_pkg::err_t               ev_code;
	logic [jtsc_pkg::DOUT_W-1:0]  ev_depth;
	logic                         ev_obj;
	logic                         out_valid_q;
	logic [jtsc_pkg::EVENT_W-1:0] event_q;
	logic [jtsc_pkg::CODE_W-1:0]  code_q;
	logic [jtsc_pkg::DOUT_W-1:0]  depth_out_q;
	logic                         obj_q;
	logic [jtsc_pkg::TAG_W-1:0]   tag_q;

	// a new word enters whenever the output register frees this cycle
	assign in_ready = !out_valid_q || out_ready;
	assign step     = in_valid && in_ready;

	// depth limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_limit_q <= jtsc_pkg::DEPTH_LIMIT_RST;
		end else if (cfg_wr_en) begin
			depth_limit_q <= cfg_wr_data;
		end
	end

	jtsc_ctrl #(
		.MAX_DEPTH (MAX_DEPTH),
		.DW        (DW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.token_kind  (token_kind),
		.depth_limit (depth_limit_q),
		.tos         (tos),
		.cmd         (cmd),
		.cur_depth   (cur_depth),
		.nxt_depth   (nxt_depth),
		.ev_kind     (ev_kind),
		.ev_code     (ev_code),
		.ev_depth    (ev_depth),
		.ev_obj      (ev_obj)
	);

	jtsc_stack #(
		.MAX_DEPTH (MAX_DEPTH),
		.DW        (DW)
	) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cur_depth (cur_depth),
		.nxt_depth (nxt_depth),
		.tos       (tos)
	);

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (step) begin
			event_q     <= ev_kind;
			code_q      <= ev_code;
			depth_out_q <= ev_depth;
			obj_q       <= ev_obj;
			tag_q       <= token_ref;
		end
	end

	assign out_valid         = out_valid_q;
	assign event_res         = event_q;
	assign error_code        = code_q;
	assign nesting_depth_out = depth_out_q;
	assign in_object         = obj_q;
	assign tag_out           = tag_q;

endmodule
